/* hw/rtl/msc_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the mips subset core: field widths, opcodes, funct and alu codes
package msc_pkg;

    localparam int XLEN       = 32;
    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = 5;
    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    localparam logic S_KIND_EXEC    = 1'b0;
    localparam logic S_KIND_PRELOAD = 1'b1;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    localparam logic [2:0] ALU_AND = 3'h0;
    localparam logic [2:0] ALU_OR  = 3'h1;
    localparam logic [2:0] ALU_ADD = 3'h2;
    localparam logic [2:0] ALU_SUB = 3'h6;
    localparam logic [2:0] ALU_SLT = 3'h7;

    localparam logic [XLEN-1:0] PC_STEP     = 32'd4;
    localparam logic [XLEN-1:0] J_KEEP_MASK = 32'hF000_0000;

endpackage

/* hw/rtl/msc_ram.sv */
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/mips_subset_single_cycle_core.sv */
`timescale 1ns / 1ps
// top level of the mips subset core: register file and data memory rams, execute and load stages
//
// channel | dir | tdata (lsb first)                                     | tuser
// s_*     | in  | instr_word, preload_word_index, preload_value          | req_type
// m_*     | out | next_pc, reg_index, reg_value, mem_word_index, mem_value | reg_written, mem_written
//
// a request reads the register file on accept, then executes and writes back from the execute stage
// lw also passes through the load stage, which waits for the registered data memory read
// the next request is accepted in the cycle the current one completes (last-write forwarding)
// reset clears pc, register valid bits and stage valids; data memory is not cleared
// a full output register stalls completion and so the input side
module mips_subset_single_cycle_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // instr_word[31:0], preload_word_index[41:32], preload_value[73:42], zero pad
    input  logic [msc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [msc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc[31:0], reg_index[36:32], reg_value[68:37], mem_word_index[78:69],
    // mem_value[110:79], zero pad
    output logic [msc_pkg::M_TDATA_W-1:0] m_tdata,
    // reg_written[0], mem_written[1]
    output logic [msc_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int XL = msc_pkg::XLEN;
    localparam int RA = msc_pkg::REG_AW;
    localparam int DA = msc_pkg::DMEM_AW;

    // input unpacking
    logic [XL-1:0] in_instr;
    logic [9:0]    in_pidx;
    logic [XL-1:0] in_pval;
    logic          in_fire;

    assign in_instr = s_tdata[31:0];
    assign in_pidx  = s_tdata[41:32];
    assign in_pval  = s_tdata[73:42];
    assign in_fire  = s_tvalid && s_tready;

    // stage registers
    logic          ex_valid_reg;
    logic          ex_kind_reg;
    logic [XL-1:0] ex_instr_reg;
    logic [DA-1:0] ex_pidx_reg;
    logic [XL-1:0] ex_pval_reg;
    logic          mem_valid_reg;
    logic [RA-1:0] mem_rt_reg;
    logic [XL-1:0] pc_reg;
    logic [XL-1:0] pc_next;

    logic [msc_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic                          fwd_valid_reg;
    logic [RA-1:0]                 fwd_idx_reg;
    logic [XL-1:0]                 fwd_val_reg;

    logic          out_valid_reg;
    logic [XL-1:0] out_pc_reg;
    logic          out_rwr_reg;
    logic [RA-1:0] out_ridx_reg;
    logic [XL-1:0] out_rval_reg;
    logic          out_mwr_reg;
    logic [DA-1:0] out_midx_reg;
    logic [XL-1:0] out_mval_reg;

    // ram ports
    logic          rf_we;
    logic [RA-1:0] rf_waddr;
    logic [XL-1:0] rf_wdata;
    logic [XL-1:0] rf_rdata_a;
    logic [XL-1:0] rf_rdata_b;
    logic          dm_we;
    logic [DA-1:0] dm_waddr;
    logic [XL-1:0] dm_wdata;
    logic          dm_re;
    logic [DA-1:0] dm_raddr;
    logic [XL-1:0] dm_rdata;

    msc_ram #(.WIDTH(XL), .DEPTH(msc_pkg::REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_fire),
        .raddr (in_instr[25:21]),
        .rdata (rf_rdata_a)
    );

    msc_ram #(.WIDTH(XL), .DEPTH(msc_pkg::REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_fire),
        .raddr (in_instr[20:16]),
        .rdata (rf_rdata_b)
    );

    msc_ram #(.WIDTH(XL), .DEPTH(msc_pkg::DMEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    // decode of the instruction in execute
    logic [5:0]    ex_op;
    logic [RA-1:0] ex_rs;
    logic [RA-1:0] ex_rt;
    logic [RA-1:0] ex_rd;
    logic [5:0]    ex_fn;
    logic [XL-1:0] ex_imm;
    logic [XL-1:0] opa;
    logic [XL-1:0] opb;
    logic [2:0]    alu_ctl;
    logic [XL-1:0] alu_res;
    logic [XL-1:0] ex_addr;
    logic [XL-1:0] pc4;
    logic          ex_is_exec;
    logic          ex_is_lw;

    assign ex_op      = ex_instr_reg[31:26];
    assign ex_rs      = ex_instr_reg[25:21];
    assign ex_rt      = ex_instr_reg[20:16];
    assign ex_rd      = ex_instr_reg[15:11];
    assign ex_fn      = ex_instr_reg[5:0];
    assign ex_imm     = {{(XL-16){ex_instr_reg[15]}}, ex_instr_reg[15:0]};
    assign ex_addr    = opa + ex_imm;
    assign pc4        = pc_reg + msc_pkg::PC_STEP;
    assign ex_is_exec = (ex_kind_reg == msc_pkg::S_KIND_EXEC);
    assign ex_is_lw   = ex_is_exec && (ex_op == msc_pkg::OP_LW);

    // operand select: register zero, last write, unwritten entry, ram
    always_comb
    begin
        if (ex_rs == '0)
            opa = '0;
        else if (fwd_valid_reg && (fwd_idx_reg == ex_rs))
            opa = fwd_val_reg;
        else if (rf_valid_reg[ex_rs])
            opa = rf_rdata_a;
        else
            opa = '0;

        if (ex_rt == '0)
            opb = '0;
        else if (fwd_valid_reg && (fwd_idx_reg == ex_rt))
            opb = fwd_val_reg;
        else if (rf_valid_reg[ex_rt])
            opb = rf_rdata_b;
        else
            opb = '0;
    end

    always_comb
    begin
        case (ex_fn)
            msc_pkg::FN_ADD: alu_ctl = msc_pkg::ALU_ADD;
            msc_pkg::FN_SUB: alu_ctl = msc_pkg::ALU_SUB;
            msc_pkg::FN_OR:  alu_ctl = msc_pkg::ALU_OR;
            msc_pkg::FN_SLT: alu_ctl = msc_pkg::ALU_SLT;
            msc_pkg::FN_AND: alu_ctl = msc_pkg::ALU_AND;
            default:         alu_ctl = msc_pkg::ALU_AND;
        endcase
    end

    always_comb
    begin
        case (alu_ctl)
            msc_pkg::ALU_ADD: alu_res = opa + opb;
            msc_pkg::ALU_SUB: alu_res = opa - opb;
            msc_pkg::ALU_OR:  alu_res = opa | opb;
            msc_pkg::ALU_SLT: alu_res = {{(XL-1){1'b0}}, ($signed(opa) < $signed(opb))};
            default:          alu_res = opa & opb;
        endcase
    end

    // completion and handshake
    logic out_free;
    logic ex_done;
    logic ex_to_mem;
    logic mem_done;

    assign out_free  = !out_valid_reg || m_tready;
    assign ex_done   = ex_valid_reg && !ex_is_lw && out_free;
    assign ex_to_mem = ex_valid_reg && ex_is_lw;
    assign mem_done  = mem_valid_reg && out_free;
    assign s_tready  = (!ex_valid_reg && !mem_valid_reg) || ex_done || mem_done;

    // result of execute
    logic          ex_rwr;
    logic [XL-1:0] ex_npc;
    logic          ex_mwr;

    always_comb
    begin
        ex_rwr = 1'b0;
        ex_mwr = 1'b0;
        ex_npc = pc4;
        if (!ex_is_exec)
        begin
            ex_npc = pc_reg;
        end
        else
        begin
            case (ex_op)
                msc_pkg::OP_RTYPE: ex_rwr = (ex_rd != '0);
                msc_pkg::OP_SW:    ex_mwr = 1'b1;
                msc_pkg::OP_BEQ:
                begin
                    if (opa == opb)
                        ex_npc = pc4 + {ex_imm[XL-3:0], 2'b00};
                end
                msc_pkg::OP_J:
                    ex_npc = (pc4 & msc_pkg::J_KEEP_MASK) | {4'b0000, ex_instr_reg[25:0], 2'b00};
                default: ex_npc = pc4;
            endcase
        end
    end

    assign pc_next = (ex_done || ex_to_mem) ? ex_npc : pc_reg;

    // register file write: r-type from execute, lw from the load stage
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = ex_rd;
        rf_wdata = alu_res;
        if (mem_done)
        begin
            rf_we    = (mem_rt_reg != '0);
            rf_waddr = mem_rt_reg;
            rf_wdata = dm_rdata;
        end
        else if (ex_done && ex_rwr)
        begin
            rf_we = 1'b1;
        end
    end

    // data memory: preload or sw write, lw read
    always_comb
    begin
        dm_we    = 1'b0;
        dm_waddr = ex_addr[DA+1:2];
        dm_wdata = opb;
        if (ex_done && !ex_is_exec)
        begin
            dm_we    = 1'b1;
            dm_waddr = ex_pidx_reg;
            dm_wdata = ex_pval_reg;
        end
        else if (ex_done && ex_mwr)
        begin
            dm_we = 1'b1;
        end
    end

    assign dm_re    = ex_to_mem;
    assign dm_raddr = ex_addr[DA+1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            rf_valid_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                ex_valid_reg <= 1'b1;
            else if (ex_done || ex_to_mem)
                ex_valid_reg <= 1'b0;

            if (ex_to_mem)
                mem_valid_reg <= 1'b1;
            else if (mem_done)
                mem_valid_reg <= 1'b0;

            if (ex_done || mem_done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            pc_reg <= pc_next;

            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
                fwd_valid_reg          <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_kind_reg  <= s_tuser[0];
            ex_instr_reg <= in_instr;
            ex_pidx_reg  <= in_pidx[DA-1:0];
            ex_pval_reg  <= in_pval;
        end
        if (ex_to_mem)
        begin
            mem_rt_reg <= ex_rt;
        end
        if (rf_we)
        begin
            fwd_idx_reg <= rf_waddr;
            fwd_val_reg <= rf_wdata;
        end
        if (mem_done)
        begin
            out_pc_reg   <= pc_reg;
            out_rwr_reg  <= rf_we;
            out_ridx_reg <= rf_we ? rf_waddr : '0;
            out_rval_reg <= rf_we ? rf_wdata : '0;
            out_mwr_reg  <= 1'b0;
            out_midx_reg <= '0;
            out_mval_reg <= '0;
        end
        else if (ex_done)
        begin
            out_pc_reg   <= ex_npc;
            out_rwr_reg  <= ex_rwr;
            out_ridx_reg <= ex_rwr ? ex_rd : '0;
            out_rval_reg <= ex_rwr ? alu_res : '0;
            out_mwr_reg  <= ex_mwr;
            out_midx_reg <= ex_mwr ? ex_addr[DA+1:2] : '0;
            out_mval_reg <= ex_mwr ? opb : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mval_reg, out_midx_reg, out_rval_reg, out_ridx_reg, out_pc_reg};
    assign m_tuser  = {out_mwr_reg, out_rwr_reg};

`ifndef SYNTH
    // one request in flight between accept and completion
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ex_valid_reg && mem_valid_reg))
        else $error("execute and load stages both busy");

    // register zero is never written
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (rf_waddr != '0))
        else $error("write to register zero");

    // a new request only enters when the load stage is empty or leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!mem_valid_reg || mem_done))
        else $error("request accepted over a pending load");

    // an accepted request occupies execute on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> ex_valid_reg)
        else $error("accepted request lost");

    // a lw leaving execute advances the pc by one word
    assert property (@(posedge clk) disable iff (!rst_n)
        ex_to_mem |=> (pc_reg == $past(pc_reg) + msc_pkg::PC_STEP))
        else $error("lw pc update wrong");
`endif

endmodule

/* test/mips_subset_single_cycle_core_tb.sv */
`timescale 1ns / 1ps
// testbench for the mips subset core: directed and random instruction streams against a predictor
module mips_subset_single_cycle_core_tb;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [31:0]                 next_pc;
        logic                        reg_written;
        logic [msc_pkg::REG_AW-1:0]  reg_index;
        logic [31:0]                 reg_value;
        logic                        mem_written;
        logic [msc_pkg::DMEM_AW-1:0] mem_word_index;
        logic [31:0]                 mem_value;
    } retire_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [msc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [msc_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [msc_pkg::M_TDATA_W-1:0] m_tdata;
    logic [msc_pkg::M_TUSER_W-1:0] m_tuser;

    // architectural state mirrored by the predictor
    logic [31:0] pc;
    logic [31:0] regs [msc_pkg::REG_COUNT];
    logic [31:0] dmem [msc_pkg::DMEM_WORDS];
    bit          dmem_valid [msc_pkg::DMEM_WORDS];
    int          written_slots [$];

    retire_t retire_q [$];
    retire_t want_r;
    retire_t got_r;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      hold_cnt = 0;
    bit      idle_on = 1'b0;

    mips_subset_single_cycle_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic retire_t execute_instr(logic kind, logic [31:0] w, logic [9:0] pidx,
                                              logic [31:0] pval);
        retire_t     r;
        logic [31:0] pc4;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [31:0] wval;
        logic [4:0]  dest;
        logic        wen;
        logic [9:0]  slot;
        r = '0;
        if (kind == msc_pkg::S_KIND_PRELOAD)
        begin
            if (!dmem_valid[pidx])
                written_slots.push_back(pidx);
            dmem[pidx] = pval;
            dmem_valid[pidx] = 1'b1;
            r.next_pc = pc;
            return r;
        end
        pc4 = pc + msc_pkg::PC_STEP;
        imm = {{16{w[15]}}, w[15:0]};
        a = regs[w[25:21]];
        b = regs[w[20:16]];
        addr = a + imm;
        slot = addr[11:2];
        wen = 1'b0;
        dest = '0;
        wval = '0;
        pc = pc4;
        case (w[31:26])
            msc_pkg::OP_RTYPE:
            begin
                wen = 1'b1;
                dest = w[15:11];
                case (w[5:0])
                    msc_pkg::FN_ADD: wval = a + b;
                    msc_pkg::FN_SUB: wval = a - b;
                    msc_pkg::FN_OR:  wval = a | b;
                    msc_pkg::FN_SLT: wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    default:         wval = a & b;
                endcase
            end
            msc_pkg::OP_LW:
            begin
                wen = 1'b1;
                dest = w[20:16];
                wval = dmem[slot];
            end
            msc_pkg::OP_SW:
            begin
                if (!dmem_valid[slot])
                    written_slots.push_back(slot);
                dmem[slot] = b;
                dmem_valid[slot] = 1'b1;
                r.mem_written = 1'b1;
                r.mem_word_index = slot;
                r.mem_value = b;
            end
            msc_pkg::OP_BEQ:
            begin
                if (a == b)
                    pc = pc4 + (imm << 2);
            end
            msc_pkg::OP_J:
            begin
                pc = (pc4 & msc_pkg::J_KEEP_MASK) | {4'b0, w[25:0], 2'b00};
            end
            default:
            begin
            end
        endcase
        // register zero stays zero
        if (wen && dest != '0)
        begin
            regs[dest] = wval;
            r.reg_written = 1'b1;
            r.reg_index = dest;
            r.reg_value = wval;
        end
        r.next_pc = pc;
        return r;
    endfunction

    function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
                                           logic [4:0] rt);
        return {msc_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] j_word(logic [25:0] target);
        return {msc_pkg::OP_J, target};
    endfunction

    // steer a load onto a word that holds data
    function automatic logic [31:0] aim_load(logic [31:0] w);
        logic [31:0] addr;
        logic [11:0] low;
        int          slot;
        addr = regs[w[25:21]] + {{16{w[15]}}, w[15:0]};
        if (w[31:26] != msc_pkg::OP_LW || dmem_valid[addr[11:2]])
            return w;
        slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
        low = {slot[9:0], 2'($urandom)} - regs[w[25:21]][11:0];
        w[11:0] = low;
        return w;
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 6)
            return 5'($urandom_range(0, 7));
        return 5'($urandom);
    endfunction

    function automatic logic [5:0] pick_fn();
        case ($urandom_range(0, 5))
            0: return msc_pkg::FN_ADD;
            1: return msc_pkg::FN_SUB;
            2: return msc_pkg::FN_AND;
            3: return msc_pkg::FN_OR;
            4: return msc_pkg::FN_SLT;
            default: return 6'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic kind, input logic [31:0] w, input logic [9:0] pidx,
                                input logic [31:0] pval);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        retire_q.push_back(execute_instr(kind, w, pidx, pval));
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, pval, pidx, w};
        s_tuser <= kind;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic exec_instr(input logic [31:0] w);
        send_request(msc_pkg::S_KIND_EXEC, w, 10'($urandom), 32'($urandom));
    endtask

    task automatic send_random_item();
        logic [31:0] w;
        logic [9:0]  pidx;
        logic [31:0] pval;
        logic [4:0]  rs;
        logic [5:0]  op;
        logic        kind;
        int          sel;
        w = $urandom;
        pidx = 10'($urandom);
        pval = $urandom;
        kind = msc_pkg::S_KIND_EXEC;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            kind = msc_pkg::S_KIND_PRELOAD;
        end
        else if (sel < 40)
        begin
            w = r_word(pick_fn(), pick_reg(), pick_reg(), pick_reg());
        end
        else if (sel < 55)
        begin
            w = i_word(msc_pkg::OP_LW, pick_reg(), pick_reg(), 16'($urandom));
        end
        else if (sel < 67)
        begin
            w = i_word(msc_pkg::OP_SW, pick_reg(), pick_reg(), 16'($urandom));
        end
        else if (sel < 80)
        begin
            rs = pick_reg();
            w = i_word(msc_pkg::OP_BEQ, rs, ($urandom_range(0, 1) == 0) ? rs : pick_reg(),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 15) - 8));
        end
        else if (sel < 87)
        begin
            w = j_word(26'($urandom));
        end
        else if (sel < 92)
        begin
            op = 6'($urandom);
            if (op == msc_pkg::OP_RTYPE || op == msc_pkg::OP_J || op == msc_pkg::OP_BEQ
                || op == msc_pkg::OP_LW || op == msc_pkg::OP_SW)
                op = 6'd63;
            w[31:26] = op;
        end
        // remaining requests are raw instruction words
        w = aim_load(w);
        send_request(kind, w, pidx, pval);
    endtask

    task automatic test_preload_and_load();
        idle_on = 1'b1;
        send_request(msc_pkg::S_KIND_PRELOAD, 32'($urandom), 10'd0, 32'h7FFF_FFFF);
        send_request(msc_pkg::S_KIND_PRELOAD, 32'($urandom), 10'd1023, 32'h8000_0000);
        send_request(msc_pkg::S_KIND_PRELOAD, 32'($urandom), 10'd5, 32'hFFFF_FFFF);
        exec_instr(i_word(msc_pkg::OP_LW, 5'd0, 5'd1, 16'h0000));
        exec_instr(i_word(msc_pkg::OP_LW, 5'd0, 5'd2, 16'h0FFC));
        exec_instr(i_word(msc_pkg::OP_LW, 5'd0, 5'd3, 16'd20));
        // low address bits are dropped
        exec_instr(i_word(msc_pkg::OP_LW, 5'd0, 5'd12, 16'd3));
    endtask

    task automatic test_alu_ops();
        idle_on = 1'b1;
        exec_instr(r_word(msc_pkg::FN_ADD, 5'd4, 5'd1, 5'd3));
        exec_instr(r_word(msc_pkg::FN_ADD, 5'd5, 5'd1, 5'd1));
        exec_instr(r_word(msc_pkg::FN_SUB, 5'd6, 5'd2, 5'd1));
        exec_instr(r_word(msc_pkg::FN_AND, 5'd7, 5'd1, 5'd3));
        exec_instr(r_word(msc_pkg::FN_OR, 5'd8, 5'd1, 5'd2));
        exec_instr(r_word(msc_pkg::FN_SLT, 5'd9, 5'd2, 5'd1));
        exec_instr(r_word(msc_pkg::FN_SLT, 5'd10, 5'd1, 5'd2));
        // unknown funct behaves as and
        exec_instr(r_word(6'h3F, 5'd11, 5'd3, 5'd1));
        // write to register zero is dropped
        exec_instr(r_word(msc_pkg::FN_ADD, 5'd0, 5'd1, 5'd1));
    endtask

    task automatic test_store_branch_jump();
        idle_on = 1'b1;
        exec_instr(i_word(msc_pkg::OP_SW, 5'd0, 5'd3, 16'hFFFC));
        exec_instr(i_word(msc_pkg::OP_SW, 5'd0, 5'd1, 16'h7FFC));
        exec_instr(i_word(msc_pkg::OP_BEQ, 5'd0, 5'd0, 16'd1));
        exec_instr(i_word(msc_pkg::OP_BEQ, 5'd1, 5'd2, 16'd5));
        exec_instr(i_word(msc_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
        exec_instr(j_word(26'h3FF_FFFF));
        // pc wraps past the top of the address space
        exec_instr(32'h0000_0000);
        exec_instr(32'hFFFF_FFFF);
        exec_instr(j_word(26'h000_0000));
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        repeat (250) send_random_item();
    endtask

    task automatic test_random_with_stalls();
        idle_on = 1'b1;
        repeat (1000) send_random_item();
    endtask

    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= gap_len();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.next_pc = m_tdata[31:0];
            got_r.reg_index = m_tdata[36:32];
            got_r.reg_value = m_tdata[68:37];
            got_r.mem_word_index = m_tdata[78:69];
            got_r.mem_value = m_tdata[110:79];
            got_r.reg_written = m_tuser[0];
            got_r.mem_written = m_tuser[1];
            if (retire_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: next_pc %h", got_r.next_pc);
            end
            else
            begin
                want_r = retire_q.pop_front();
                if (got_r.next_pc !== want_r.next_pc
                    || got_r.reg_written !== want_r.reg_written
                    || got_r.reg_index !== want_r.reg_index
                    || got_r.reg_value !== want_r.reg_value
                    || got_r.mem_written !== want_r.mem_written
                    || got_r.mem_word_index !== want_r.mem_word_index
                    || got_r.mem_value !== want_r.mem_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("mismatch exp/got: pc %h/%h reg %b/%b %0d/%0d %h/%h ",
                               want_r.next_pc, got_r.next_pc,
                               want_r.reg_written, got_r.reg_written,
                               want_r.reg_index, got_r.reg_index,
                               want_r.reg_value, got_r.reg_value);
                        $display("mem %b/%b %0d/%0d %h/%h",
                                 want_r.mem_written, got_r.mem_written,
                                 want_r.mem_word_index, got_r.mem_word_index,
                                 want_r.mem_value, got_r.mem_value);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        pc = '0;
        foreach (regs[i])
            regs[i] = '0;
        foreach (dmem[i])
            dmem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_preload_and_load();
        test_alu_ops();
        test_store_branch_jump();
        test_random_back_to_back();
        test_random_with_stalls();
        s_tvalid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/msc_pkg.sv
hw/rtl/msc_ram.sv
hw/rtl/mips_subset_single_cycle_core.sv
test/mips_subset_single_cycle_core_tb.sv
